[design/button_edge_and_ramped_axis_defines.svh]
// ----------------------------------------------------------------------------
// button_edge_and_ramped_axis_defines
// Assertion macros used by the button/axis top-level design file.
// ----------------------------------------------------------------------------
`ifndef BUTTON_EDGE_AND_RAMPED_AXIS_DEFINES_SVH
`define BUTTON_EDGE_AND_RAMPED_AXIS_DEFINES_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define BERA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk_i, off during reset
`define BERA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/bera_pkg.sv]
// ----------------------------------------------------------------------------
// bera_pkg
// Types and constants of the button phase tracker and ramped axis.
// ----------------------------------------------------------------------------
package bera_pkg;

  localparam int BTN_W      = 16;
  localparam int DT_W       = 16;
  localparam int VAL_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 28;
  localparam int RATE_W     = 28;
  localparam int DZ_W       = 15;

  // button phase codes
  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_PRESS = 2'd1,
    PH_HELD  = 2'd2,
    PH_REL   = 2'd3
  } bera_phase_e;

  // register indexes of the config port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PLUS_MASK  = 3'd0,
    CFG_MINUS_MASK = 3'd1,
    CFG_ACCEL_RATE = 3'd2,
    CFG_DECAY_RATE = 3'd3,
    CFG_DEAD_ZONE  = 3'd4,
    CFG_SNAP_EN    = 3'd5
  } bera_cfg_e;

  // per-tick button status, after the phase update
  typedef struct packed {
    logic [BTN_W-1:0] pressed;
    logic [BTN_W-1:0] held;
    logic [BTN_W-1:0] released;
    logic [BTN_W-1:0] active;
    logic             any;
  } bera_btn_t;

endpackage

[design/bera_cfg_if.sv]
// ----------------------------------------------------------------------------
// bera_cfg_if
// Register write channel: index and data with valid/ready.
// ----------------------------------------------------------------------------
interface bera_cfg_if import bera_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[design/bera_in_if.sv]
// ----------------------------------------------------------------------------
// bera_in_if
// Input tick channel: raw buttons and elapsed time with valid/ready.
// ----------------------------------------------------------------------------
interface bera_in_if import bera_pkg::*;;
  logic             valid;
  logic             ready;
  logic [BTN_W-1:0] button_bits;
  logic [DT_W-1:0]  tick_delta;

  modport source (output valid, button_bits, tick_delta, input ready);
  modport sink   (input valid, button_bits, tick_delta, output ready);
endinterface

[design/bera_out_if.sv]
// ----------------------------------------------------------------------------
// bera_out_if
// Result channel: axis value and button phase masks with valid/ready.
// ----------------------------------------------------------------------------
interface bera_out_if import bera_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] axis_value;
  logic [BTN_W-1:0]        pressed_now;
  logic [BTN_W-1:0]        held_now;
  logic [BTN_W-1:0]        released_now;
  logic                    any_pressed;

  modport source (output valid, axis_value, pressed_now, held_now, released_now,
                  any_pressed, input ready);
  modport sink   (input valid, axis_value, pressed_now, held_now, released_now,
                  any_pressed, output ready);
endinterface

[design/bera_phase.sv]
// ----------------------------------------------------------------------------
// bera_phase
// Four-phase tracker per button; status reflects the phase after this tick.
// ----------------------------------------------------------------------------
module bera_phase import bera_pkg::*; #(
  parameter int NUM_BUTTONS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             upd_i,
  input  logic [BTN_W-1:0] bits_i,
  output bera_btn_t        info_o
);

  localparam int DW    = (NUM_BUTTONS > BTN_W) ? NUM_BUTTONS : BTN_W;
  localparam int NB_IO = (NUM_BUTTONS < BTN_W) ? NUM_BUTTONS : BTN_W;

  bera_phase_e ph_q [NUM_BUTTONS];
  bera_phase_e ph_d [NUM_BUTTONS];
  logic [DW-1:0] down_v;

  // buttons past the input width see a released level
  assign down_v = DW'(bits_i);

  function automatic bera_phase_e next_phase(bera_phase_e ph, logic down);
    bera_phase_e nx;
    if (down) begin
      unique case (ph)
        PH_IDLE:  nx = PH_PRESS;
        PH_PRESS: nx = PH_HELD;
        PH_HELD:  nx = PH_HELD;
        default:  nx = PH_PRESS;
      endcase
    end else begin
      unique case (ph)
        PH_PRESS: nx = PH_REL;
        PH_HELD:  nx = PH_REL;
        default:  nx = PH_IDLE;
      endcase
    end
    return nx;
  endfunction

  always_comb begin
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      ph_d[i] = next_phase(ph_q[i], down_v[i]);
    end
  end

  always_comb begin
    info_o = '0;
    for (int i = 0; i < NB_IO; i++) begin
      info_o.active[i]   = (ph_d[i] != PH_IDLE);
      info_o.pressed[i]  = (ph_d[i] == PH_PRESS);
      info_o.held[i]     = (ph_d[i] == PH_HELD);
      info_o.released[i] = (ph_d[i] == PH_REL);
    end
    info_o.any = |down_v[NB_IO-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_BUTTONS; i++) ph_q[i] <= PH_IDLE;
    end else if (upd_i) begin
      for (int i = 0; i < NUM_BUTTONS; i++) ph_q[i] <= ph_d[i];
    end
  end

endmodule

[design/button_edge_and_ramped_axis.sv]
// ----------------------------------------------------------------------------
// button_edge_and_ramped_axis
// Button phase tracker driving one ramped, self-centering virtual axis.
// ----------------------------------------------------------------------------
// Each input word is one tick: raw button levels plus elapsed time (Q0.16 s).
// Every button steps through idle / just pressed / held / just released, and
// each tick yields one result word with the new axis value (Q2.14, clamped to
// +-1) and the pressed/held/released masks. A tick holds the block through the
// accept cycle and four sequencer steps, with the result word registered at
// the end of the last step. When both axis sides are pushed the arithmetic
// is skipped and the sequencer goes from the accept cycle straight to the
// last step. A new tick is taken the cycle after the previous one finishes,
// even while its result still waits downstream; that tick then stalls in its
// last step until the result register frees up. The steps follow from the
// single 28x16 multiplier, used twice per computed tick under a small
// sequencer: first rate*dt (accel or decay step), then |speed|*dt (position
// move). Config writes are always taken; write only while the block is idle.
// ----------------------------------------------------------------------------
`include "button_edge_and_ramped_axis_defines.svh"

module button_edge_and_ramped_axis import bera_pkg::*; #(
  parameter int NUM_BUTTONS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  bera_cfg_if.sink   cfg_i,
  bera_in_if.sink    in_i,
  bera_out_if.source out_o
);

  localparam int W = 30;  // working width for speed/position math
  localparam logic signed [W-1:0] SPD_LIM = 30'sd163840000;
  localparam logic signed [W-1:0] VAL_ONE = 30'sd16384;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MUL1 = 5'b00010,
    S_UPD  = 5'b00100,
    S_MUL2 = 5'b01000,
    S_FIN  = 5'b10000
  } bera_state_e;

  // config registers
  logic [BTN_W-1:0]  plus_mask_q, minus_mask_q;
  logic [RATE_W-1:0] accel_q, decay_q;
  logic [DZ_W-1:0]   dead_zone_q;
  logic              snap_q;

  // sequencer and state
  bera_state_e state_q, state_d;
  logic signed [VAL_W-1:0] pos_q;
  logic signed [28:0]      spd_q;

  // per-tick working registers
  logic [DT_W-1:0]       dt_q;
  logic                  plus_q, minus_q;
  logic [RATE_W-1:0]     prod_q;
  logic signed [W-1:0]   work_q;
  logic signed [28:0]    wspd_q;
  bera_btn_t             btn_q;

  // result register
  logic                    out_valid_q;
  logic signed [VAL_W-1:0] out_val_q;
  bera_btn_t               out_btn_q;

  bera_btn_t btn_info;
  logic      in_fire, cfg_fire, out_load, both_push;

  assign in_i.ready  = (state_q == S_IDLE);
  assign in_fire     = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;
  assign cfg_fire    = cfg_i.valid && cfg_i.ready;
  assign both_push   = plus_q && minus_q;
  assign out_load    = (state_q == S_FIN) && (!out_valid_q || out_o.ready);

  bera_phase #(.NUM_BUTTONS(NUM_BUTTONS)) u_phase (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .upd_i  (in_fire),
    .bits_i (in_i.button_bits),
    .info_o (btn_info)
  );

  // ---- config write decode; unknown indexes are dropped ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plus_mask_q  <= '0;
      minus_mask_q <= '0;
      accel_q      <= '0;
      decay_q      <= '0;
      dead_zone_q  <= '0;
      snap_q       <= 1'b0;
    end else if (cfg_fire) begin
      unique case (cfg_i.index)
        CFG_PLUS_MASK:  plus_mask_q  <= cfg_i.data[BTN_W-1:0];
        CFG_MINUS_MASK: minus_mask_q <= cfg_i.data[BTN_W-1:0];
        CFG_ACCEL_RATE: accel_q      <= cfg_i.data[RATE_W-1:0];
        CFG_DECAY_RATE: decay_q      <= cfg_i.data[RATE_W-1:0];
        CFG_DEAD_ZONE:  dead_zone_q  <= cfg_i.data[DZ_W-1:0];
        CFG_SNAP_EN:    snap_q       <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  // ---- shared multiplier: operand A picked by the step ----
  logic [28:0]        spd_abs;
  logic [RATE_W-1:0]  mul_a;
  logic [RATE_W+DT_W-1:0] mul_p;

  assign spd_abs = wspd_q[28] ? 29'(-wspd_q) : 29'(wspd_q);

  always_comb begin
    if (state_q == S_MUL2) begin
      mul_a = spd_abs[RATE_W-1:0];     // |speed| never exceeds 28 bits
    end else if (plus_q || minus_q) begin
      mul_a = accel_q;
    end else begin
      mul_a = decay_q;
    end
  end

  assign mul_p = mul_a * dt_q;

  // ---- speed / position update (one active side, or decay) ----
  logic signed [W-1:0] pos_w, spd_w, step_w, dz_w, upd_pos, upd_spd;

  assign pos_w  = {{(W-VAL_W){pos_q[VAL_W-1]}}, pos_q};
  assign spd_w  = {spd_q[28], spd_q};
  assign step_w = {2'b00, prod_q};
  assign dz_w   = {{(W-DZ_W){1'b0}}, dead_zone_q};

  always_comb begin
    upd_pos = pos_w;
    upd_spd = spd_w;
    if (plus_q) begin
      if (snap_q && pos_q < 0) upd_pos = '0;
      upd_spd = spd_w + step_w;
      if (upd_spd > SPD_LIM) upd_spd = SPD_LIM;
    end else if (minus_q) begin
      if (snap_q && pos_q > 0) upd_pos = '0;
      upd_spd = spd_w - step_w;
      if (upd_spd < -SPD_LIM) upd_spd = -SPD_LIM;
    end else begin
      // decay toward zero, zeroed inside the dead zone
      if (pos_q > 0) begin
        upd_pos = pos_w - step_w;
        if (upd_pos < dz_w) upd_pos = '0;
      end else begin
        upd_pos = pos_w + step_w;
        if (upd_pos > -dz_w) upd_pos = '0;
      end
      upd_spd = '0;
    end
  end

  // ---- final move by speed*dt and clamp to +-1 ----
  logic signed [W-1:0] fin_sum, fin_clamp;

  always_comb begin
    fin_sum = wspd_q[28] ? (work_q - step_w) : (work_q + step_w);
    if (fin_sum > VAL_ONE) begin
      fin_clamp = VAL_ONE;
    end else if (fin_sum < -VAL_ONE) begin
      fin_clamp = -VAL_ONE;
    end else begin
      fin_clamp = fin_sum;
    end
  end

  // ---- sequencer ----
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          // both sides pushed: nothing to compute
          if (|(btn_info.active & plus_mask_q) && |(btn_info.active & minus_mask_q)) begin
            state_d = S_FIN;
          end else begin
            state_d = S_MUL1;
          end
        end
      end
      S_MUL1: state_d = S_UPD;
      S_UPD:  state_d = S_MUL2;
      S_MUL2: state_d = S_FIN;
      S_FIN: begin
        if (out_load) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pos_q       <= '0;
      spd_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
        if (!both_push) begin
          pos_q <= fin_clamp[VAL_W-1:0];
          spd_q <= wspd_q;
        end
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      dt_q    <= in_i.tick_delta;
      btn_q   <= btn_info;
      plus_q  <= |(btn_info.active & plus_mask_q);
      minus_q <= |(btn_info.active & minus_mask_q);
    end
    if (state_q == S_MUL1 || state_q == S_MUL2) begin
      prod_q <= mul_p[RATE_W+DT_W-1:DT_W];
    end
    if (state_q == S_UPD) begin
      work_q <= upd_pos;
      wspd_q <= upd_spd[28:0];
    end
    if (out_load) begin
      out_val_q <= both_push ? pos_q : fin_clamp[VAL_W-1:0];
      out_btn_q <= btn_q;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.axis_value   = out_val_q;
  assign out_o.pressed_now  = out_btn_q.pressed;
  assign out_o.held_now     = out_btn_q.held;
  assign out_o.released_now = out_btn_q.released;
  assign out_o.any_pressed  = out_btn_q.any;

  // ---- assertions ----
  `BERA_ASSERT_IMP(a_pos_range, 1'b1, (pos_w <= VAL_ONE) && (pos_w >= -VAL_ONE), "axis position out of range")
  `BERA_ASSERT_IMP(a_spd_range, 1'b1, (spd_w <= SPD_LIM) && (spd_w >= -SPD_LIM), "axis speed out of range")
  `BERA_ASSERT_NXT(a_busy_after_accept, in_fire, !in_i.ready, "took a tick while busy")
  `BERA_ASSERT_NXT(a_hold_keeps_state, out_load && both_push, $stable(pos_q) && $stable(spd_q), "axis moved with both sides pushed")
  `BERA_ASSERT_NXT(a_load_sets_valid, out_load, out_valid_q, "result lost at load")

endmodule

[dv/tb_button_edge_and_ramped_axis.sv]
// ----------------------------------------------------------------------------
// tb_button_edge_and_ramped_axis
// Self-checking bench for the button phase tracker and its ramped axis.
// ----------------------------------------------------------------------------
// Tick words go in over the input channel. Each accepted tick is run through
// an in-bench model of the phase machines and the axis (ramp, saturation,
// snap on reversal, decay through the dead zone, clamp). Its expected result
// word is queued, and every result word taken from the block is compared
// field by field with the oldest entry. Directed tests walk the phase
// transitions and the axis corner cases. Random traffic then runs under four
// idle/stall mixes, with the registers reloaded between bursts while the
// block is idle.
// ----------------------------------------------------------------------------
module tb_button_edge_and_ramped_axis;
  timeunit 1ns;
  timeprecision 1ps;

  import bera_pkg::*;

  localparam longint SPEED_LIMIT  = 163840000;  // 10000 value units per second
  localparam longint VALUE_ONE    = 16384;      // 1.0 in Q2.14
  localparam int     DRAIN_CYCLES = 12;         // one full tick plus margin

  // indexes with no register behind them; writes must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_B = 3'd7;

  typedef struct {
    logic signed [VAL_W-1:0] value;
    logic [BTN_W-1:0]        pressed;
    logic [BTN_W-1:0]        held;
    logic [BTN_W-1:0]        released;
    logic                    any;
  } axis_result_t;

  logic clk_i      = 1'b0;
  logic rst_ni     = 1'b0;
  logic recv_ready = 1'b0;

  bera_cfg_if reg_if ();
  bera_in_if  tick_if ();
  bera_out_if result_if ();

  assign result_if.ready = recv_ready;

  button_edge_and_ramped_axis #(
    .NUM_BUTTONS(16)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (reg_if),
    .in_i  (tick_if),
    .out_o (result_if)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Axis model state: phase per button, speed, position and register copies.
  // All of it is zero after reset, which is only applied once.
  // --------------------------------------------------------------------------
  bera_phase_e       phase_q [BTN_W] = '{default: PH_IDLE};
  longint            speed_q   = 0;
  longint            pos_q     = 0;
  logic [BTN_W-1:0]  plus_mask_q  = '0;
  logic [BTN_W-1:0]  minus_mask_q = '0;
  logic [RATE_W-1:0] accel_q = '0;
  logic [RATE_W-1:0] decay_q = '0;
  logic [DZ_W-1:0]   dead_q  = '0;
  logic              snap_q  = 1'b0;

  axis_result_t expected_ticks [$];
  int error_count    = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  function automatic bera_phase_e next_phase(bera_phase_e ph, logic down);
    if (down) begin
      if (ph == PH_PRESS || ph == PH_HELD) return PH_HELD;
      return PH_PRESS;
    end
    if (ph == PH_PRESS || ph == PH_HELD) return PH_REL;
    return PH_IDLE;
  endfunction

  // exact rate*dt product, dropping the 16 fraction bits of dt
  function automatic longint scaled_step(logic [RATE_W-1:0] rate, logic [DT_W-1:0] dt);
    longint unsigned prod;
    prod = 64'(rate) * 64'(dt);
    return longint'(prod >> 16);
  endfunction

  function automatic axis_result_t advance_axis(logic [BTN_W-1:0] bits,
                                                logic [DT_W-1:0] dt);
    axis_result_t r;
    logic [BTN_W-1:0] active;
    logic   push_up, push_down;
    longint pos, spd, drop, move;
    int     i;
    r.pressed  = '0;
    r.held     = '0;
    r.released = '0;
    r.any      = |bits;
    active     = '0;
    for (i = 0; i < BTN_W; i++) begin
      phase_q[i] = next_phase(phase_q[i], bits[i]);
      active[i]     = (phase_q[i] != PH_IDLE);
      r.pressed[i]  = (phase_q[i] == PH_PRESS);
      r.held[i]     = (phase_q[i] == PH_HELD);
      r.released[i] = (phase_q[i] == PH_REL);
    end
    push_up   = |(active & plus_mask_q);
    push_down = |(active & minus_mask_q);
    // both sides pushing freezes speed and value
    if (!(push_up && push_down)) begin
      pos = pos_q;
      spd = speed_q;
      if (push_up) begin
        if (snap_q && pos < 0) pos = 0;
        spd += scaled_step(accel_q, dt);
        if (spd > SPEED_LIMIT) spd = SPEED_LIMIT;
      end else if (push_down) begin
        if (snap_q && pos > 0) pos = 0;
        spd -= scaled_step(accel_q, dt);
        if (spd < -SPEED_LIMIT) spd = -SPEED_LIMIT;
      end else begin
        // decay toward zero; zero and negative values take the rising branch
        drop = scaled_step(decay_q, dt);
        if (pos > 0) begin
          pos -= drop;
          if (pos < longint'(dead_q)) pos = 0;
        end else begin
          pos += drop;
          if (pos > -longint'(dead_q)) pos = 0;
        end
        spd = 0;
      end
      // |speed| never exceeds the limit, which fits the rate width
      move = scaled_step(RATE_W'(spd < 0 ? -spd : spd), dt);
      pos += (spd < 0) ? -move : move;
      if (pos > VALUE_ONE) pos = VALUE_ONE;
      if (pos < -VALUE_ONE) pos = -VALUE_ONE;
      pos_q   = pos;
      speed_q = spd;
    end
    r.value = VAL_W'(pos_q);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Predict on every accepted tick word, check on every accepted result word.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && tick_if.valid && tick_if.ready)
      expected_ticks.push_back(advance_axis(tick_if.button_bits, tick_if.tick_delta));
  end

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("%0t ns: %s mismatch, got %h want %h", $realtime, field, got, want);
    error_count++;
  endtask

  always @(posedge clk_i) begin
    axis_result_t want;
    if (rst_ni && result_if.valid && result_if.ready) begin
      if (expected_ticks.size() == 0) begin
        report_mismatch("unrequested result", 32'(result_if.axis_value), '0);
      end else begin
        want = expected_ticks.pop_front();
        if (result_if.axis_value !== want.value)
          report_mismatch("axis_value", 32'(result_if.axis_value), 32'(want.value));
        if (result_if.pressed_now !== want.pressed)
          report_mismatch("pressed_now", 32'(result_if.pressed_now), 32'(want.pressed));
        if (result_if.held_now !== want.held)
          report_mismatch("held_now", 32'(result_if.held_now), 32'(want.held));
        if (result_if.released_now !== want.released)
          report_mismatch("released_now", 32'(result_if.released_now),
                          32'(want.released));
        if (result_if.any_pressed !== want.any)
          report_mismatch("any_pressed", 32'(result_if.any_pressed), 32'(want.any));
      end
    end
  end

  // downstream backpressure, redrawn every cycle
  always @(posedge clk_i) recv_ready <= ($urandom_range(99) >= recv_stall_pct);

  // --------------------------------------------------------------------------
  // Channel drivers. Valid is left high after a word is taken so that back to
  // back words never drop it; whoever ends a burst lowers it.
  // --------------------------------------------------------------------------
  task automatic send_tick(logic [BTN_W-1:0] bits, logic [DT_W-1:0] dt);
    while ($urandom_range(99) < send_idle_pct) begin
      tick_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    tick_if.valid       <= 1'b1;
    tick_if.button_bits <= bits;
    tick_if.tick_delta  <= dt;
    do @(posedge clk_i); while (!tick_if.ready);
  endtask

  // stop sending, let every queued result come back, then let the block settle
  task automatic wait_idle();
    tick_if.valid <= 1'b0;
    @(posedge clk_i);
    while (expected_ticks.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    reg_if.valid <= 1'b1;
    reg_if.index <= idx;
    reg_if.data  <= data;
    do @(posedge clk_i); while (!reg_if.ready);
    case (idx)
      CFG_PLUS_MASK:  plus_mask_q  = data[BTN_W-1:0];
      CFG_MINUS_MASK: minus_mask_q = data[BTN_W-1:0];
      CFG_ACCEL_RATE: accel_q      = data[RATE_W-1:0];
      CFG_DECAY_RATE: decay_q      = data[RATE_W-1:0];
      CFG_DEAD_ZONE:  dead_q       = data[DZ_W-1:0];
      CFG_SNAP_EN:    snap_q       = data[0];
      default: ;
    endcase
  endtask

  // full reload; bits above each register's width carry junk on purpose
  task automatic configure(logic [BTN_W-1:0] plus, logic [BTN_W-1:0] minus,
                           logic [RATE_W-1:0] accel, logic [RATE_W-1:0] decay,
                           logic [DZ_W-1:0] dz, logic snap);
    wait_idle();
    write_reg(CFG_UNMAPPED_A, CFG_DATA_W'($urandom()));
    write_reg(CFG_PLUS_MASK,  {12'($urandom()), plus});
    write_reg(CFG_MINUS_MASK, {12'($urandom()), minus});
    write_reg(CFG_ACCEL_RATE, accel);
    write_reg(CFG_DECAY_RATE, decay);
    write_reg(CFG_DEAD_ZONE,  {13'($urandom()), dz});
    write_reg(CFG_SNAP_EN,    {27'($urandom()), snap});
    write_reg(CFG_UNMAPPED_B, CFG_DATA_W'($urandom()));
    reg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // reset config (no masks): every phase transition, field extremes
  task automatic test_phase_walk();
    send_tick(16'h0000, 16'h0000);
    send_tick(16'hFFFF, 16'hFFFF);  // idle -> just pressed
    send_tick(16'hFFFF, 16'h0000);  // just pressed -> held
    send_tick(16'hFFFF, 16'h0001);  // held stays held
    send_tick(16'h0000, 16'h8000);  // held -> just released
    send_tick(16'hFFFF, 16'h7FFF);  // just released -> just pressed
    send_tick(16'h0000, 16'hFFFF);  // just pressed -> just released
    send_tick(16'h0000, 16'h0000);  // just released -> idle
    send_tick(16'hAAAA, 16'h1234);
    send_tick(16'h5555, 16'hABCD);
  endtask

  // max accel: speed saturates upward, value saturates both ways, both sides hold,
  // decay from below zero brings the value up to exactly zero
  task automatic test_ramp_and_hold();
    configure(16'h0001, 16'h0100, '1, 28'h0100000, '0, 1'b0);
    send_tick(16'h0001, 16'hFFFF);
    send_tick(16'h0001, 16'h0100);
    send_tick(16'h0101, 16'hFFFF);  // both sides: frozen
    send_tick(16'h0000, 16'h0100);
    send_tick(16'h0100, 16'hFFFF);
    send_tick(16'h0000, 16'h0100);  // released minus button still pushes down
    send_tick(16'h0000, 16'h0400);  // decays upward to exactly zero
    send_tick(16'h0000, 16'h0000);  // decay from exactly zero
    send_tick(16'h0001, 16'h0001);
    send_tick(16'h0001, 16'h0010);
  endtask

  // snap on reversal, with dead zone and decay set above their normal range
  task automatic test_snap_and_dead_zone();
    configure(16'h8000, 16'h0080, 28'h0800000, '1, '1, 1'b1);
    send_tick(16'h8000, 16'hFFFF);
    send_tick(16'h8000, 16'hFFFF);
    send_tick(16'h0080, 16'h4000);  // both sides active: frozen before the snap
    send_tick(16'h0080, 16'hFFFF);
    send_tick(16'h0000, 16'h0001);  // released minus button still pushes down
    send_tick(16'h8000, 16'h2000);
  endtask

  task automatic configure_random(bit extreme);
    logic [BTN_W-1:0]  plus, minus;
    logic [RATE_W-1:0] accel, decay;
    logic [DZ_W-1:0]   dz;
    if (extreme) begin
      plus  = $urandom_range(1) ? '1 : '0;
      minus = $urandom_range(1) ? '1 : '0;
      accel = $urandom_range(1) ? '1 : '0;
      decay = $urandom_range(1) ? '1 : '0;
      dz    = $urandom_range(1) ? '1 : '0;
    end else begin
      plus  = BTN_W'($urandom_range(65535) & $urandom_range(65535));
      minus = BTN_W'($urandom_range(65535) & $urandom_range(65535));
      case ($urandom_range(2))
        0:       accel = RATE_W'($urandom_range(163840000));
        1:       accel = RATE_W'($urandom_range(2000000));
        default: accel = RATE_W'($urandom());
      endcase
      case ($urandom_range(2))
        0:       decay = RATE_W'($urandom_range(20000000));
        1:       decay = RATE_W'($urandom_range(400000));
        default: decay = RATE_W'($urandom());
      endcase
      dz = $urandom_range(1) ? DZ_W'($urandom_range(2000)) : DZ_W'($urandom());
    end
    configure(plus, minus, accel, decay, dz, 1'(($urandom_range(1))));
  endtask

  // mostly held button groups so speeds can ramp; some random button patterns
  task automatic run_ticks(int count);
    logic [BTN_W-1:0] bits;
    logic [DT_W-1:0]  dt;
    bits = '0;
    repeat (count) begin
      case ($urandom_range(9))
        0, 1, 2, 3, 4, 5: ;  // keep the same buttons down
        6:       bits = BTN_W'($urandom_range(65535)) & plus_mask_q;
        7:       bits = BTN_W'($urandom_range(65535)) & minus_mask_q;
        8:       bits = '0;
        default: bits = BTN_W'($urandom_range(65535));
      endcase
      case ($urandom_range(3))
        0:       dt = DT_W'($urandom_range(65535));
        1:       dt = DT_W'($urandom_range(4095));
        2:       dt = DT_W'($urandom_range(511));
        default: dt = DT_W'($urandom_range(65535, 49152));
      endcase
      send_tick(bits, dt);
    end
  endtask

  task automatic test_random_traffic(int idle_pct, int stall_pct);
    int k;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (k = 0; k < 4; k++) begin
      configure_random(k == 0);
      run_ticks(58);
    end
  endtask

  initial begin
    tick_if.valid       = 1'b0;
    tick_if.button_bits = '0;
    tick_if.tick_delta  = '0;
    reg_if.valid        = 1'b0;
    reg_if.index        = '0;
    reg_if.data         = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_phase_walk();
    test_ramp_and_hold();
    test_snap_and_dead_zone();
    test_random_traffic(0, 0);
    test_random_traffic(54, 0);
    test_random_traffic(0, 54);
    test_random_traffic(11, 11);

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

[filelist.f]
+incdir+design
design/bera_pkg.sv
design/bera_cfg_if.sv
design/bera_in_if.sv
design/bera_out_if.sv
design/bera_phase.sv
design/button_edge_and_ramped_axis.sv
dv/tb_button_edge_and_ramped_axis.sv
